// File: sv/clfmt_pkg.sv
// shared types, constants and helper functions for the character lcd write formatter
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package clfmt_pkg;

   typedef enum logic [1:0] {
      OP_INIT   = 2'd0,
      OP_CHAR   = 2'd1,
      OP_NUMBER = 2'd2,
      OP_APPEND = 2'd3
   } op_type;

   localparam logic [7:0] CMD_SET_ADDR   = 8'h80;
   localparam logic [7:0] LINE2_OFFSET   = 8'h40;
   localparam logic [7:0] CMD_CLEAR      = 8'h01;
   localparam logic [7:0] CMD_FUNC_SET   = 8'h38;
   localparam logic [7:0] CMD_DISP_ON    = 8'h0C;
   localparam logic [7:0] CMD_ENTRY_MODE = 8'h06;
   localparam logic [7:0] ASCII_ZERO     = 8'h30;
   localparam logic [1:0] LINE_ONE       = 2'd1;
   localparam logic [1:0] LINE_TWO       = 2'd2;

   // body index runs over at most five bytes
   localparam int BODY_IDX_W = 3;

   localparam logic [BODY_IDX_W-1:0] LAST_IDX_INIT   = 3'd3;
   localparam logic [BODY_IDX_W-1:0] LAST_IDX_NUMBER = 3'd4;
   localparam logic [BODY_IDX_W-1:0] LAST_IDX_SINGLE = 3'd0;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // one classified item between front and back
   typedef struct packed {
      op_type                  op;
      logic                    has_cursor;
      logic [7:0]              cursor_byte;
      logic [BODY_IDX_W-1:0]   last_idx;
      logic [7:0]              char_value;
      logic [15:0]             number_value;
   } entry_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   function automatic logic [7:0] init_byte(input logic [BODY_IDX_W-1:0] idx);
      logic [7:0] b;
      case (idx)
         3'd0:    b = CMD_CLEAR;
         3'd1:    b = CMD_FUNC_SET;
         3'd2:    b = CMD_DISP_ON;
         default: b = CMD_ENTRY_MODE;
      endcase
      return b;
   endfunction

   function automatic logic [15:0] pow10(input logic [BODY_IDX_W-1:0] idx);
      logic [15:0] p;
      case (idx)
         3'd0:    p = 16'd10000;
         3'd1:    p = 16'd1000;
         3'd2:    p = 16'd100;
         3'd3:    p = 16'd10;
         default: p = 16'd1;
      endcase
      return p;
   endfunction

   // leading decimal digit of rem for weight pow, rem < 10*pow
   function automatic logic [3:0] digit_of(input logic [15:0] rem, input logic [15:0] pow);
      logic [3:0] d;
      d = 4'd0;
      for (int k = 1; k < 10; k++) begin
         if ({1'b0, rem} >= 17'(17'(k) * {1'b0, pow}))
            d = 4'(k);
      end
      return d;
   endfunction

endpackage

// File: sv/clfmt_front.sv
// front: classifies a request into a queue entry (cursor byte, body length)
// depends on clfmt_pkg
`timescale 1ns / 1ps

module clfmt_front (
   input  logic [1:0]           opcode_i,
   input  logic [1:0]           line_i,
   input  logic [5:0]           column_i,
   input  logic [7:0]           char_value_i,
   input  logic [15:0]          number_value_i,
   output clfmt_pkg::entry_type entry_o
);
   import clfmt_pkg::*;

   op_type     op;
   logic [7:0] base;
   logic       positioned;

   always_comb begin
      op         = op_type'(opcode_i);
      positioned = (op == OP_CHAR) || (op == OP_NUMBER);
      base       = (line_i == LINE_TWO) ? (CMD_SET_ADDR + LINE2_OFFSET) : CMD_SET_ADDR;

      entry_o.op           = op;
      entry_o.has_cursor   = positioned && ((line_i == LINE_ONE) || (line_i == LINE_TWO));
      // address wraps modulo 256, column counted from 1
      entry_o.cursor_byte  = base + {2'b00, column_i} - 8'd1;
      entry_o.char_value   = char_value_i;
      entry_o.number_value = number_value_i;
      case (op)
         OP_INIT:   entry_o.last_idx = LAST_IDX_INIT;
         OP_NUMBER: entry_o.last_idx = LAST_IDX_NUMBER;
         default:   entry_o.last_idx = LAST_IDX_SINGLE;
      endcase
   end

endmodule

// File: sv/clfmt_queue.sv
// small queue of classified entries between front and back
// depends on clfmt_pkg
`timescale 1ns / 1ps

module clfmt_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push_i,
   input  clfmt_pkg::entry_type        push_entry_i,
   input  logic                        pop_i,
   output clfmt_pkg::entry_type        head_o,
   output clfmt_pkg::queue_status_type status_o
);
   import clfmt_pkg::*;

   entry_type               mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]  count_ff, count_in;

   always_comb begin
      wr_ptr_in = push_i ? QUEUE_PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop_i  ? QUEUE_PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push_i && !pop_i)
         count_in = QUEUE_CNT_W'(count_ff + 1'b1);
      else if (pop_i && !push_i)
         count_in = QUEUE_CNT_W'(count_ff - 1'b1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_i)
         mem_ff[wr_ptr_ff] <= push_entry_i;
   end

   assign head_o         = mem_ff[rd_ptr_ff];
   assign status_o.empty = (count_ff == '0);
   assign status_o.full  = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));

endmodule

// File: sv/clfmt_back.sv
// back: sequences one entry into byte writes, one byte a cycle, registered output
// depends on clfmt_pkg
`timescale 1ns / 1ps

module clfmt_back (
   input  logic                        clock,
   input  logic                        reset,
   input  clfmt_pkg::entry_type        head_i,
   input  clfmt_pkg::queue_status_type status_i,
   output logic                        pop_o,
   output logic                        strobe_o,
   output logic                        is_data_o,
   output logic [7:0]                  data_byte_o,
   output logic                        last_o
);
   import clfmt_pkg::*;

   logic                   busy_ff;
   logic                   cur_ff;
   op_type                 op_ff;
   logic [7:0]             cursor_ff;
   logic [7:0]             char_ff;
   logic [15:0]            rem_ff;
   logic [BODY_IDX_W-1:0]  idx_ff;
   logic [BODY_IDX_W-1:0]  last_idx_ff;
   logic                   strobe_ff;
   logic                   is_data_ff;
   logic [7:0]             byte_ff;
   logic                   last_ff;

   logic                   finishing;
   logic                   load;
   logic [15:0]            pow;
   logic [3:0]             digit;
   logic [15:0]            rem_in;
   logic [7:0]             body_byte;
   logic                   body_is_data;

   always_comb begin
      finishing = busy_ff && !cur_ff && (idx_ff == last_idx_ff);
      load      = (!busy_ff || finishing) && !status_i.empty;
      pow       = pow10(idx_ff);
      digit     = digit_of(rem_ff, pow);
      rem_in    = rem_ff - 16'(20'(digit) * 20'(pow));
      case (op_ff)
         OP_INIT: begin
            body_byte    = init_byte(idx_ff);
            body_is_data = 1'b0;
         end
         OP_NUMBER: begin
            body_byte    = ASCII_ZERO + {4'd0, digit};
            body_is_data = 1'b1;
         end
         default: begin
            body_byte    = char_ff;
            body_is_data = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         cur_ff    <= 1'b0;
         strobe_ff <= 1'b0;
         last_ff   <= 1'b0;
      end else begin
         strobe_ff <= busy_ff;
         // last is only ever high together with the strobe
         last_ff   <= finishing;
         if (busy_ff) begin
            if (cur_ff) begin
               is_data_ff <= 1'b0;
               byte_ff    <= cursor_ff;
            end else begin
               is_data_ff <= body_is_data;
               byte_ff    <= body_byte;
            end
         end
         // next entry starts right behind the last byte of this one
         if (load) begin
            busy_ff     <= 1'b1;
            cur_ff      <= head_i.has_cursor;
            op_ff       <= head_i.op;
            cursor_ff   <= head_i.cursor_byte;
            char_ff     <= head_i.char_value;
            rem_ff      <= head_i.number_value;
            idx_ff      <= '0;
            last_idx_ff <= head_i.last_idx;
         end else if (busy_ff) begin
            if (cur_ff) begin
               cur_ff <= 1'b0;
            end else begin
               idx_ff <= BODY_IDX_W'(idx_ff + 1'b1);
               rem_ff <= rem_in;
               if (finishing)
                  busy_ff <= 1'b0;
            end
         end
      end
   end

   assign pop_o       = load;
   assign strobe_o    = strobe_ff;
   assign is_data_o   = is_data_ff;
   assign data_byte_o = byte_ff;
   assign last_o      = last_ff;

endmodule

// File: sv/char_lcd_write_formatter_top.sv
// top level of the character lcd write formatter: front, entry queue, back
// depends on clfmt_pkg, clfmt_front, clfmt_queue, clfmt_back
`timescale 1ns / 1ps

// Turns display requests into byte writes for a 16x2 character LCD.
// Request channel: drive req_* and raise start; the request is taken at a
// rising edge where start is high and busy is low. busy is high only while
// the two-entry queue between front and back is full.
// Result channel: each byte shows on rsp_is_data / rsp_data_byte / rsp_last
// for exactly one cycle with rsp_strobe high; rsp_last marks the final byte
// of a request. The receiver cannot stall, so nothing is ever held back.
// Bytes per request: init 4, char 1 or 2, number 5 or 6, append 1.
// The back end sends one byte per cycle; a request has 6 bytes at most,
// for a positioned number. The next request's first byte follows its
// predecessor's last byte with no gap when it is already queued. Decimal
// digits are formed one per cycle. With the queue empty and the back end
// idle, a taken request is written into the queue, then loaded into the
// back end's registers; its first byte is then registered to the outputs.
// Reset clears the queue and the sequencer; no strobe until a request arrives.

module char_lcd_write_formatter_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_opcode,
   input  logic [1:0]  req_line,
   input  logic [5:0]  req_column,
   input  logic [7:0]  req_char_value,
   input  logic [15:0] req_number_value,
   output logic        rsp_strobe,
   output logic        rsp_is_data,
   output logic [7:0]  rsp_data_byte,
   output logic        rsp_last
);
   import clfmt_pkg::*;

   entry_type        new_entry;
   entry_type        head;
   queue_status_type status;
   logic             push;
   logic             pop;

   assign busy = status.full;
   assign push = start && !busy;

   clfmt_front u_front (
      .opcode_i       (req_opcode),
      .line_i         (req_line),
      .column_i       (req_column),
      .char_value_i   (req_char_value),
      .number_value_i (req_number_value),
      .entry_o        (new_entry)
   );

   clfmt_queue u_queue (
      .clock        (clock),
      .reset        (reset),
      .push_i       (push),
      .push_entry_i (new_entry),
      .pop_i        (pop),
      .head_o       (head),
      .status_o     (status)
   );

   clfmt_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_i      (head),
      .status_i    (status),
      .pop_o       (pop),
      .strobe_o    (rsp_strobe),
      .is_data_o   (rsp_is_data),
      .data_byte_o (rsp_data_byte),
      .last_o      (rsp_last)
   );

   a_last_needs_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_last |-> rsp_strobe)
      else $error("last flag without strobe");

   a_busy_rises_on_accept: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("queue filled without a request");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty)
      else $error("entry taken from empty queue");

endmodule
